[hdl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the base64
// stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  // Saturating byte counter
  localparam int unsigned COUNT_W = 21;
  localparam longint unsigned MAX_OUTPUT_BYTES = 64'd1048576;
  localparam longint unsigned COUNT_FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(
    (MAX_OUTPUT_BYTES > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_OUTPUT_BYTES);

  // Symbol encoding: bit 6 marks padding, bits 5..0 hold the value
  localparam int unsigned SYM_W = 7;
  localparam int unsigned PAD_BIT = 6;
  localparam logic [5:0] SYM_PLUS = 6'd62;
  localparam logic [5:0] SYM_SLASH = 6'd63;
  localparam logic [5:0] OFS_LOWER = 6'd26;
  localparam logic [5:0] OFS_DIGIT = 6'd52;

  // Result queue
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MAX_RESULTS = 3;

  // One input word
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } char_t;

  // One result word
  typedef struct packed {
    logic [7:0]         data_byte;
    logic               byte_valid;
    logic               run_last;
    logic               stream_done;
    logic [COUNT_W-1:0] total_bytes;
  } res_t;

  // Burst of up to three results from one character
  typedef struct packed {
    logic [1:0]       n;
    res_t [2:0]       entry;
  } push_t;

  // Classifier output
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } sym_t;

  // Map a raw character to a symbol; hit is low for skipped bytes
  function automatic sym_t classify(input logic [7:0] ch);
    sym_t r;
    r.hit = 1'b1;
    r.sym = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.sym = {1'b0, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r.sym = {1'b0, 6'(ch - 8'h61) + OFS_LOWER};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r.sym = {1'b0, 6'(ch - 8'h30) + OFS_DIGIT};
    end else if (ch == 8'h2B) begin
      r.sym = {1'b0, SYM_PLUS};
    end else if (ch == 8'h2F) begin
      r.sym = {1'b0, SYM_SLASH};
    end else if (ch == 8'h3D) begin
      r.sym = {1'b1, 6'd0};
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/b64d_decode.sv]
// ----------------------------------------------------------------------------
// b64d_decode
// Input holding register, symbol grouping and byte extraction. Pushes up to
// three result words per character into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_decode (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  char_valid,
  output logic                 char_stall,
  input  b64d_pkg::char_t      char_word,
  input  wire                  space_ok,
  output b64d_pkg::push_t      push
);

  // Holding register
  logic            hold_valid;
  b64d_pkg::char_t hold;

  // Decoder state
  logic [b64d_pkg::SYM_W-1:0]   store [3];
  logic [1:0]                   sym_count;
  logic                         halted;
  logic [b64d_pkg::COUNT_W-1:0] byte_count;

  logic                         advance;
  b64d_pkg::sym_t               cls;
  logic                         sym_hit;
  logic                         full_grp;
  logic                         bad;
  logic                         emit;
  logic [5:0]                   cv;
  logic [5:0]                   dv;
  logic [23:0]                  triple;
  logic [1:0]                   nb;
  logic [b64d_pkg::COUNT_W-1:0] cnt [3];
  logic [b64d_pkg::COUNT_W-1:0] byte_count_next;
  logic [b64d_pkg::SYM_W-1:0]   c_sym;
  logic [b64d_pkg::SYM_W-1:0]   d_sym;

  assign advance    = hold_valid && space_ok;
  assign char_stall = hold_valid && !space_ok;

  // Load a new word whenever the holding register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!char_stall) begin
      hold_valid <= char_valid;
    end
    if (!char_stall && char_valid) begin
      hold <= char_word;
    end
  end

  // Group decode
  always_comb begin
    cls      = b64d_pkg::classify(hold.text_byte);
    sym_hit  = cls.hit && !halted;
    full_grp = sym_hit && (sym_count == 2'd3);
    bad      = store[0][b64d_pkg::PAD_BIT] || store[1][b64d_pkg::PAD_BIT];
    emit     = full_grp && !bad;
    c_sym    = store[2];
    d_sym    = cls.sym;
    cv       = c_sym[b64d_pkg::PAD_BIT] ? 6'd0 : c_sym[5:0];
    dv       = d_sym[b64d_pkg::PAD_BIT] ? 6'd0 : d_sym[5:0];
    triple   = {store[0][5:0], store[1][5:0], cv, dv};
    nb       = emit ? (2'd1 + {1'b0, !c_sym[b64d_pkg::PAD_BIT]}
                            + {1'b0, !d_sym[b64d_pkg::PAD_BIT]}) : 2'd0;
  end

  // Saturating running count after each emitted byte
  always_comb begin
    logic [b64d_pkg::COUNT_W:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = {1'b0, byte_count} + (b64d_pkg::COUNT_W + 1)'(k + 1);
      cnt[k] = (sum > {1'b0, b64d_pkg::COUNT_CAP}) ? b64d_pkg::COUNT_CAP
                                                    : sum[b64d_pkg::COUNT_W-1:0];
    end
    byte_count_next = byte_count;
    if (nb != 2'd0) begin
      byte_count_next = cnt[nb - 2'd1];
    end
  end

  // Build the result burst
  always_comb begin
    push = '0;
    push.entry[0].data_byte   = triple[23:16];
    push.entry[0].byte_valid  = 1'b1;
    push.entry[0].total_bytes = cnt[0];
    push.entry[1].data_byte   = c_sym[b64d_pkg::PAD_BIT] ? triple[7:0] : triple[15:8];
    push.entry[1].byte_valid  = 1'b1;
    push.entry[1].total_bytes = cnt[1];
    push.entry[2].data_byte   = triple[7:0];
    push.entry[2].byte_valid  = 1'b1;
    push.entry[2].total_bytes = cnt[2];
    push.n = nb;
    // End of string with no byte: one status-only word
    if (hold.end_of_string && nb == 2'd0) begin
      push.n = 2'd1;
      push.entry[0].data_byte   = 8'd0;
      push.entry[0].byte_valid  = 1'b0;
      push.entry[0].total_bytes = byte_count;
    end
    if (!advance) begin
      push.n = 2'd0;
    end
    if (push.n != 2'd0) begin
      push.entry[push.n - 2'd1].run_last    = 1'b1;
      push.entry[push.n - 2'd1].stream_done = hold.end_of_string;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_count  <= 2'd0;
      halted     <= 1'b0;
      byte_count <= '0;
    end else if (advance) begin
      if (hold.end_of_string) begin
        sym_count  <= 2'd0;
        halted     <= 1'b0;
        byte_count <= '0;
      end else if (sym_hit) begin
        if (sym_count != 2'd3) begin
          sym_count <= sym_count + 2'd1;
        end else begin
          sym_count  <= 2'd0;
          halted     <= bad;
          byte_count <= byte_count_next;
        end
      end
    end
  end

  // Symbol store, no reset
  always_ff @(posedge clk) begin
    if (advance && sym_hit && sym_count != 2'd3) begin
      store[sym_count] <= cls.sym;
    end
  end

  // End of string always leaves a clean state
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && hold.end_of_string) |=>
      (sym_count == 2'd0 && !halted && byte_count == '0))
    else $error("state not cleared after end of string");

  // Counter never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= b64d_pkg::COUNT_CAP)
    else $error("byte count above cap");

  // A halted decoder holds no partial group
  a_halt_empty: assert property (@(posedge clk) disable iff (rst)
    halted |-> sym_count == 2'd0)
    else $error("halted with symbols held");

endmodule

`default_nettype wire

[hdl/b64d_fifo.sv]
// ----------------------------------------------------------------------------
// b64d_fifo
// Result queue: takes up to three words per cycle, hands out one per cycle unless res_stall holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_fifo (
  input  wire              clk,
  input  wire              rst,
  input  b64d_pkg::push_t  push,
  output logic             space_ok,
  output logic             res_valid,
  input  wire              res_stall,
  output b64d_pkg::res_t   res_word
);

  b64d_pkg::res_t                mem [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QPTR_W-1:0]   head;
  logic [b64d_pkg::QPTR_W-1:0]   tail;
  logic [b64d_pkg::QCNT_W-1:0]   count;
  logic                          pop;

  assign res_valid = (count != '0);
  assign res_word  = mem[head];
  assign pop       = res_valid && !res_stall;
  // Room for a full burst
  assign space_ok  = (count <= b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH
                                                - b64d_pkg::MAX_RESULTS));

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + b64d_pkg::QPTR_W'(push.n);
      head  <= head + b64d_pkg::QPTR_W'(pop);
      count <= count + b64d_pkg::QCNT_W'(push.n) - b64d_pkg::QCNT_W'(pop);
    end
  end

  // Storage writes
  always_ff @(posedge clk) begin
    for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++) begin
      if (k < int'(push.n)) begin
        mem[tail + b64d_pkg::QPTR_W'(k)] <= push.entry[k];
      end
    end
  end

  // Fill level stays within depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // Bursts only arrive when they fit
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> ((count + b64d_pkg::QCNT_W'(push.n))
                           <= b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH)))
    else $error("push exceeds free space");

  // A lone pop drops the level by one
  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    (pop && push.n == 2'd0) |=> (count == $past(count) - b64d_pkg::QCNT_W'(1)))
    else $error("fill level wrong after pop");

endmodule

`default_nettype wire

[hdl/base64_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder: one character word in, decoded byte words out.
// ----------------------------------------------------------------------------
// Path: an accepted character is decoded from the holding register, and its
//   result words are registered in the result queue before they can be taken.
// Throughput: one character per cycle and, while the receiver does not stall, one result word per cycle; input
//   stalls while the 8-entry result queue has fewer than 3 free entries.
// Reset (rst, synchronous): clears group state, halt flag, count and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_unit (
  input  wire              clk,
  input  wire              rst,
  input  wire              char_valid,
  output logic             char_stall,
  input  b64d_pkg::char_t  char_word,
  output logic             res_valid,
  input  wire              res_stall,
  output b64d_pkg::res_t   res_word
);

  b64d_pkg::push_t push;
  logic            space_ok;

  // Decode stage
  b64d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .space_ok   (space_ok),
    .push       (push)
  );

  // Result queue
  b64d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

`default_nettype wire

[tb/tb_base64_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_unit
// Self-checking bench for the streaming base64 decoder. Character words are
// sent through the valid/stall input channel while a scoreboard, fed by a
// bit-accurate decoder written here, checks every result word in order.
// Directed strings cover the byte extremes, padding forms, halting and
// partial groups; random strings follow under three idling mixes, with one
// long receiver hold-off that backs the decoder up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base64_stream_decoder_unit;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 11;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_LEN = 100;
  localparam int HOLD_CHARS = 48;
  localparam int RANDOM_CHARS = 45;

  // Symbol classes used by the decoder model
  localparam int SYM_SKIP = -1;
  localparam int SYM_PAD = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  b64d_pkg::char_t char_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  b64d_pkg::res_t res_word;

  // Idling mix, in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Receiver hold-off control
  logic hold_start = 1'b0;
  int hold_left = 0;

  // Decoder model state
  logic [6:0] sym_hold [3];
  int unsigned sym_cnt = 0;
  logic halt_q = 1'b0;
  logic [b64d_pkg::COUNT_W-1:0] byte_total = '0;
  b64d_pkg::res_t burst [3];
  int nburst;

  // Expected result words, oldest first
  b64d_pkg::res_t pending_bytes [$];

  int err_count = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int words_checked = 0;
  int stall_cycles = 0;

  base64_stream_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word)
  );

  always #CLK_HALF clk = ~clk;

  // Value of a character in the alphabet, or skip / pad
  function automatic int sym_of(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A");
    if (ch >= "a" && ch <= "z") return int'(ch) - int'("a") + 26;
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0") + 52;
    if (ch == "+") return 62;
    if (ch == "/") return 63;
    if (ch == "=") return SYM_PAD;
    return SYM_SKIP;
  endfunction

  // Character that encodes a 6-bit value
  function automatic logic [7:0] char_of(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // One result word into the current burst
  function automatic void add_word(input logic [7:0] v, input logic vld);
    b64d_pkg::res_t r;
    r = '0;
    r.data_byte = v;
    r.byte_valid = vld;
    r.total_bytes = byte_total;
    burst[nburst] = r;
    nburst++;
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    if (byte_total < b64d_pkg::COUNT_CAP) byte_total++;
    add_word(v, 1'b1);
  endfunction

  // Decode one accepted character and queue the words it causes
  function automatic void decode_char(input logic [7:0] ch, input logic eos);
    int s;
    logic [6:0] d;
    logic [5:0] cv, dv;
    logic [23:0] grp;
    nburst = 0;
    if (!halt_q) begin
      s = sym_of(ch);
      if (s != SYM_SKIP) begin
        d = 7'(s);
        if (sym_cnt < 3) begin
          sym_hold[sym_cnt] = d;
          sym_cnt++;
        end else begin
          sym_cnt = 0;
          if (sym_hold[0][6] || sym_hold[1][6]) begin
            halt_q = 1'b1;
          end else begin
            cv = sym_hold[2][6] ? 6'd0 : sym_hold[2][5:0];
            dv = d[6] ? 6'd0 : d[5:0];
            grp = {sym_hold[0][5:0], sym_hold[1][5:0], cv, dv};
            add_byte(grp[23:16]);
            if (!sym_hold[2][6]) add_byte(grp[15:8]);
            if (!d[6]) add_byte(grp[7:0]);
          end
        end
      end
    end
    if (eos) begin
      if (nburst == 0) add_word(8'h00, 1'b0);
      burst[nburst-1].stream_done = 1'b1;
      sym_cnt = 0;
      halt_q = 1'b0;
      byte_total = '0;
    end
    if (nburst > 0) burst[nburst-1].run_last = 1'b1;
    for (int i = 0; i < nburst; i++) pending_bytes.push_back(burst[i]);
  endfunction

  // Offer one character word and wait until it is taken
  task automatic send_char(input logic [7:0] ch, input logic eos);
    b64d_pkg::char_t w;
    w.text_byte = ch;
    w.end_of_string = eos;
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word <= w;
    @(posedge clk);
    while (char_stall) begin
      stall_cycles++;
      @(posedge clk);
    end
    decode_char(ch, eos);
    chars_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic send_str(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eos_last && (i == s.len() - 1));
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // Random string: mostly well-formed groups with stray filler, some pure noise
  task automatic send_random_string(input int n_groups, input int no_filler);
    logic [7:0] text [$];
    int kind, tail, filler;
    logic [7:0] junk [5];
    junk = '{8'h20, 8'h0A, 8'h0D, 8'h09, 8'h80};
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
    end else begin
      for (int g = 0; g < n_groups; g++) begin
        for (int k = 0; k < 4; k++) text.push_back(char_of($urandom_range(63)));
      end
      tail = $urandom_range(9);
      case (tail)
        1: text[text.size()-1] = "=";
        2: begin
          text[text.size()-1] = "=";
          text[text.size()-2] = "=";
        end
        3: text[text.size()-2] = "=";
        4: begin
          // pad early: decoder halts, rest of the string is ignored
          text[text.size()-4 + $urandom_range(1)] = "=";
          repeat ($urandom_range(1, 6)) text.push_back(char_of($urandom_range(63)));
        end
        5: repeat ($urandom_range(1, 3)) void'(text.pop_back());
        default: ;
      endcase
      if (!no_filler) begin
        filler = $urandom_range(3);
        repeat (filler) begin
          text.insert($urandom_range(text.size()), junk[$urandom_range(4)] |
                      8'($urandom_range(1) ? 0 : $urandom_range(127) << 1));
        end
      end
    end
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // Idle the input and wait for every expected word
  task automatic drain;
    char_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Directed strings: extremes, padding forms, halting, partial groups
  task automatic test_directed;
    send_char("/", 1'b0);
    send_char("/", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("/", 1'b0);
    send_char("/", 1'b1);
    send_char("A", 1'b0);
    send_char(8'h00, 1'b0);
    send_str("AAA", 1'b1);
    send_str("QU=B", 1'b1);
    send_str("QQ==", 1'b1);
    send_str("=AAAZ", 1'b1);
    send_str("z9+\t", 1'b1);
    drain();
  endtask

  task automatic test_random(input int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_random_string($urandom_range(1, 5), 1'b0);
    drain();
  endtask

  // Long receiver hold-off while the sender keeps the input busy
  task automatic test_backpressure;
    int stall_mark;
    stall_mark = stall_cycles;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < HOLD_CHARS; i++) begin
      send_char(char_of($urandom_range(63)), i == HOLD_CHARS - 1);
    end
    drain();
    if (stall_cycles == stall_mark) begin
      $display("%0t: note: hold-off did not stall the input", $time);
    end
  endtask

  // Receiver stall: random mix, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_LEN;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(input string what, input longint want,
                                      input longint got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, what, want, want, got, got);
    end
  endfunction

  // Scoreboard: each taken result word against the oldest expectation
  always @(posedge clk) begin
    b64d_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_bytes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result word, expected none, got %p", $time, res_word);
      end else begin
        want = pending_bytes.pop_front();
        check_field("data_byte", want.data_byte, res_word.data_byte);
        check_field("byte_valid", want.byte_valid, res_word.byte_valid);
        check_field("run_last", want.run_last, res_word.run_last);
        check_field("stream_done", want.stream_done, res_word.stream_done);
        check_field("total_bytes", want.total_bytes, res_word.total_bytes);
        words_checked++;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(16, 58);
    test_directed();
    test_random(RANDOM_CHARS);
    set_idling(58, 16);
    test_random(RANDOM_CHARS);
    set_idling(0, 0);
    test_backpressure();
    test_random(RANDOM_CHARS);
    drain();
    if (pending_bytes.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected result words never arrived", $time, pending_bytes.size());
    end
    $display("Sent %0d strings (%0d characters), checked %0d result words;",
             strings_sent, chars_sent, words_checked);
    $display("input held off for %0d cycles under receiver back-pressure.", stall_cycles);
    if (err_count == 0) begin
      $display("base64_stream_decoder_unit regression: pass");
    end else begin
      $display("base64_stream_decoder_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("%0t: timeout with %0d result words outstanding", $time, pending_bytes.size());
    $display("base64_stream_decoder_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/b64d_pkg.sv
hdl/b64d_decode.sv
hdl/b64d_fifo.sv
hdl/base64_stream_decoder_unit.sv
tb/tb_base64_stream_decoder_unit.sv
